/* rtl/pal_pkg.sv */
package pal_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = CNT_W + 1;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INS_START,
    DP_INS_MOVE,
    DP_INS_PUT,
    DP_REM_START,
    DP_REM_TAKE,
    DP_REM_MOVE,
    DP_REM_END,
    DP_SRCH_START,
    DP_SRCH_STEP,
    DP_CLEAR,
    DP_PUBLISH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_MOVE,
    ST_INS_PUT,
    ST_REM_TAKE,
    ST_REM_MOVE,
    ST_REM_END,
    ST_SRCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t cmd;
    logic ins_ok;
    logic rem_ok;
    logic ins_nomove;
    logic at_pos;
    logic at_end;
    logic hit;
    logic count_zero;
  } dp_status_t;

endpackage

/* rtl/pal_dp.sv */
module pal_dp
  import pal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_op_t                  op,
  output dp_status_t              status,
  input  logic [1:0]              command,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    ok,
  output logic [POS_W-1:0]        found_position,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [POS_W-1:0]        length,
  output logic                    is_empty,
  output logic                    is_full
);

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  cmd_t             req_cmd;
  logic [POS_W-1:0] req_pos;
  logic [VAL_W-1:0] req_val;

  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ra;
  logic [ADDR_W-1:0] ra_next;

  logic             res_ok;
  logic [POS_W-1:0] res_found;
  logic [VAL_W-1:0] res_removed;

  logic [ADDR_W-1:0] pos_m1;
  logic [ADDR_W-1:0] cnt_m1;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  assign pos_m1 = ADDR_W'(req_pos - POS_W'(1));
  assign cnt_m1 = ADDR_W'(count - CNT_W'(1));

  assign status.cmd        = req_cmd;
  assign status.ins_ok     = (count < CNT_W'(CAPACITY)) && (req_pos != '0)
                             && (CMP_W'(req_pos) <= CMP_W'(count) + CMP_W'(1));
  assign status.rem_ok     = (count != '0) && (req_pos != '0)
                             && (CMP_W'(req_pos) <= CMP_W'(count));
  assign status.ins_nomove = CMP_W'(req_pos) == CMP_W'(count) + CMP_W'(1);
  assign status.at_pos     = ra == pos_m1;
  assign status.at_end     = ra == cnt_m1;
  assign status.hit        = rdata == req_val;
  assign status.count_zero = count == '0;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ra;
    wr_en   = 1'b0;
    wr_addr = ra;
    wr_data = rdata;
    ra_next = ra;
    case (op)
      DP_INS_START: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1;
        ra_next = cnt_m1;
      end
      DP_INS_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ra + ADDR_W'(1);
        rd_en   = 1'b1;
        rd_addr = ra - ADDR_W'(1);
        ra_next = ra - ADDR_W'(1);
      end
      DP_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1;
        wr_data = req_val;
      end
      DP_REM_START: begin
        rd_en   = 1'b1;
        rd_addr = pos_m1;
        ra_next = pos_m1;
      end
      DP_REM_TAKE, DP_SRCH_STEP: begin
        rd_en   = 1'b1;
        rd_addr = ra + ADDR_W'(1);
        ra_next = ra + ADDR_W'(1);
      end
      DP_REM_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = ra - ADDR_W'(1);
        rd_en   = 1'b1;
        rd_addr = ra + ADDR_W'(1);
        ra_next = ra + ADDR_W'(1);
      end
      DP_SRCH_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        ra_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        DP_INS_PUT: count <= count + CNT_W'(1);
        DP_REM_END: count <= count - CNT_W'(1);
        DP_CLEAR:   count <= '0;
        default:    count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ra <= ra_next;
    case (op)
      DP_LOAD: begin
        req_cmd     <= cmd_t'(command);
        req_pos     <= position;
        req_val     <= value;
        res_ok      <= 1'b0;
        res_found   <= '0;
        res_removed <= '0;
      end
      DP_INS_PUT, DP_REM_END, DP_CLEAR: begin
        res_ok <= 1'b1;
      end
      DP_REM_TAKE: begin
        res_removed <= rdata;
      end
      DP_SRCH_STEP: begin
        if (status.hit) begin
          res_ok    <= 1'b1;
          res_found <= POS_W'(ra) + POS_W'(1);
        end
      end
      DP_PUBLISH: begin
        ok             <= res_ok;
        found_position <= res_found;
        removed_value  <= res_removed;
        length         <= POS_W'(count);
        is_empty       <= count == '0;
        is_full        <= count == CNT_W'(CAPACITY);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/pal_ctrl.sv */
module pal_ctrl
  import pal_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_INSERT: begin
            if (!status.ins_ok)         state_next = ST_FINISH;
            else if (status.ins_nomove) state_next = ST_INS_PUT;
            else                        state_next = ST_INS_MOVE;
          end
          CMD_REMOVE: state_next = status.rem_ok ? ST_REM_TAKE : ST_FINISH;
          CMD_SEARCH: state_next = status.count_zero ? ST_FINISH : ST_SRCH;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_INS_MOVE: begin
        if (status.at_pos) state_next = ST_INS_PUT;
      end
      ST_INS_PUT: state_next = ST_FINISH;
      ST_REM_TAKE: state_next = status.at_end ? ST_REM_END : ST_REM_MOVE;
      ST_REM_MOVE: begin
        if (status.at_end) state_next = ST_REM_END;
      end
      ST_REM_END: state_next = ST_FINISH;
      ST_SRCH: begin
        if (status.hit || status.at_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = DP_NOP;
    case (state)
      ST_IDLE: op = in_valid ? DP_LOAD : DP_NOP;
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_INSERT: op = (status.ins_ok && !status.ins_nomove) ? DP_INS_START : DP_NOP;
          CMD_REMOVE: op = status.rem_ok ? DP_REM_START : DP_NOP;
          CMD_SEARCH: op = status.count_zero ? DP_NOP : DP_SRCH_START;
          default:    op = DP_CLEAR;
        endcase
      end
      ST_INS_MOVE: op = DP_INS_MOVE;
      ST_INS_PUT:  op = DP_INS_PUT;
      ST_REM_TAKE: op = DP_REM_TAKE;
      ST_REM_MOVE: op = DP_REM_MOVE;
      ST_REM_END:  op = DP_REM_END;
      ST_SRCH:     op = DP_SRCH_STEP;
      ST_FINISH:   op = out_free ? DP_PUBLISH : DP_NOP;
      default:     op = DP_NOP;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) out_valid_next = 1'b0;
    if (state == ST_FINISH && out_free) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/positional_array_list_unit.sv */
// channel  handshake            payload
// in       in_valid / in_ready  command, position, value
// out      out_valid/out_ready  ok, found_position, removed_value, length, is_empty, is_full
//
// one request at a time; the list lives in a 128 x 32 memory with one read and one write port
// insert shifts entries from the tail down to p, remove shifts those after p forward, search scans
// from the head to a hit or the end; the walk moves one entry per cycle through the memory
// a finished result sits in the output register while the next request is taken
// rst is synchronous and empties the list; memory contents are not cleared
module positional_array_list_unit
  import pal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ok,
  output logic [POS_W-1:0]        found_position,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [POS_W-1:0]        length,
  output logic                    is_empty,
  output logic                    is_full
);

  dp_op_t     op;
  dp_status_t status;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  pal_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .status         (status),
    .command        (command),
    .position       (position),
    .value          (value),
    .ok             (ok),
    .found_position (found_position),
    .removed_value  (removed_value),
    .length         (length),
    .is_empty       (is_empty),
    .is_full        (is_full)
  );

endmodule

/* tb/pal_list_checker.sv */
`timescale 1ns / 1ps

module pal_list_checker
  import pal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              command,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    ok,
  input  logic [POS_W-1:0]        found_position,
  input  logic signed [VAL_W-1:0] removed_value,
  input  logic [POS_W-1:0]        length,
  input  logic                    is_empty,
  input  logic                    is_full,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found_position;
    logic [VAL_W-1:0] removed_value;
    logic [POS_W-1:0] length;
    logic             is_empty;
    logic             is_full;
  } list_outcome_t;

  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               used;
  list_outcome_t    outcomes [$];

  function automatic list_outcome_t apply_list_op(cmd_t op, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] val);
    list_outcome_t r;
    int            p;
    int            j;
    r = '0;
    p = int'(pos);
    case (op)
      CMD_INSERT: begin
        if (used < CAPACITY && p >= 1 && p <= used + 1) begin
          for (j = used; j >= p; j--) list_mem[j] = list_mem[j-1];
          list_mem[p-1] = val;
          used++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (used > 0 && p >= 1 && p <= used) begin
          r.removed_value = list_mem[p-1];
          for (j = p; j < used; j++) list_mem[j-1] = list_mem[j];
          used--;
          r.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        for (j = 0; j < used; j++) begin
          if (!r.ok && list_mem[j] == val) begin
            r.found_position = POS_W'(j + 1);
            r.ok = 1'b1;
          end
        end
      end
      default: begin
        used = 0;
        r.ok = 1'b1;
      end
    endcase
    r.length   = POS_W'(used);
    r.is_empty = (used == 0);
    r.is_full  = (used == CAPACITY);
    return r;
  endfunction

  always @(posedge clk) begin
    list_outcome_t want;
    list_outcome_t got;
    if (rst) begin
      used = 0;
      outcomes.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{ok, found_position, removed_value, length, is_empty, is_full};
        if (outcomes.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result ok=%0b pos=%0d removed=%0d len=%0d e=%0b f=%0b",
                     $realtime, ok, found_position, removed_value, length, is_empty, is_full);
          errors++;
        end else begin
          want = outcomes.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $write("%0t: mismatch expected ok=%0b pos=%0d removed=%0d len=%0d e=%0b f=%0b",
                     $realtime, want.ok, want.found_position, $signed(want.removed_value),
                     want.length, want.is_empty, want.is_full);
              $display(" got ok=%0b pos=%0d removed=%0d len=%0d e=%0b f=%0b",
                       ok, found_position, removed_value, length, is_empty, is_full);
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        outcomes.push_back(apply_list_op(cmd_t'(command), position, value));
    end
    pending = outcomes.size();
  end

endmodule

/* tb/positional_array_list_unit_tb.sv */
`timescale 1ns / 1ps

module positional_array_list_unit_tb;
  import pal_pkg::*;

  typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    ok;
  logic [POS_W-1:0]        found_position;
  logic signed [VAL_W-1:0] removed_value;
  logic [POS_W-1:0]        length;
  logic                    is_empty;
  logic                    is_full;
  int                      errors;
  int                      pending;

  int               list_len;
  int               sent;
  int               steady_lo;
  logic             steady;
  logic [VAL_W-1:0] seen_vals [16];
  int               seen_wr;

  positional_array_list_unit DUT (.*);
  pal_list_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk)
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 23);

  task automatic send_request(input cmd_t op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int p;
    p = int'(pos);
    steady = (sent >= steady_lo && sent < steady_lo + 180);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= op;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    case (op)
      CMD_INSERT: begin
        if (list_len < CAPACITY && p >= 1 && p <= list_len + 1) begin
          list_len++;
          seen_vals[seen_wr] = val;
          seen_wr = (seen_wr + 1) % 16;
        end
      end
      CMD_REMOVE: if (list_len > 0 && p >= 1 && p <= list_len) list_len--;
      CMD_CLEAR:  list_len = 0;
      default: ;
    endcase
    sent++;
  endtask

  function automatic logic [POS_W-1:0] pick_position(cmd_t op);
    int unsigned r;
    int          hi;
    r  = $urandom_range(0, 99);
    hi = (op == CMD_INSERT) ? list_len + 1 : list_len;
    if (op == CMD_SEARCH || op == CMD_CLEAR) return POS_W'($urandom_range(0, 255));
    if (hi > CAPACITY) hi = CAPACITY + 1;
    if (r < 10 || hi == 0) begin
      if ($urandom_range(0, 2) == 0) return '0;
      return POS_W'($urandom_range(hi + 1, 255));
    end
    if (r < 25) return POS_W'(1);
    if (r < 40) return POS_W'(hi);
    return POS_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(cmd_t op);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    if (r < 30) return VAL_W'($urandom_range(0, 7));
    if (op == CMD_SEARCH && r < 75) return seen_vals[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  initial begin
    int unsigned      roll;
    phase_t           ph;
    int               phase_items;
    int               extra;
    int               turn;
    int               k;
    cmd_t             op;
    logic             done;
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = CMD_CLEAR;
    position  = '0;
    value     = '0;
    list_len  = 0;
    sent      = 0;
    seen_wr   = 0;
    steady    = 1'b0;
    steady_lo = $urandom_range(300, 600);
    foreach (seen_vals[i]) seen_vals[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_request(CMD_CLEAR,  8'd0,   32'h0);
    send_request(CMD_REMOVE, 8'd1,   32'h0);
    send_request(CMD_SEARCH, 8'd0,   32'h0);
    send_request(CMD_INSERT, 8'd0,   32'd5);
    send_request(CMD_INSERT, 8'd2,   32'd5);
    send_request(CMD_INSERT, 8'd1,   32'h8000_0000);
    send_request(CMD_INSERT, 8'd2,   32'h7fff_ffff);
    send_request(CMD_INSERT, 8'd1,   32'hffff_ffff);
    send_request(CMD_INSERT, 8'd4,   32'h0);
    send_request(CMD_INSERT, 8'd3,   32'h0);
    send_request(CMD_SEARCH, 8'd0,   32'h0);
    send_request(CMD_SEARCH, 8'd0,   32'h8000_0000);
    send_request(CMD_SEARCH, 8'hff,  32'd12345);
    send_request(CMD_INSERT, 8'hff,  32'd9);
    send_request(CMD_REMOVE, 8'd0,   32'h0);
    send_request(CMD_REMOVE, 8'd6,   32'h0);
    send_request(CMD_REMOVE, 8'd3,   32'h0);
    send_request(CMD_REMOVE, 8'd4,   32'h0);
    send_request(CMD_REMOVE, 8'd1,   32'h0);
    send_request(CMD_SEARCH, 8'h80,  32'h7fff_ffff);
    send_request(CMD_CLEAR,  8'hff,  32'hffff_ffff);
    send_request(CMD_SEARCH, 8'd1,   32'hffff_ffff);

    ph          = PH_FILL;
    phase_items = 0;
    extra       = 0;
    turn        = 0;
    for (k = 0; k < 1050; k++) begin
      roll = $urandom_range(0, 99);
      case (ph)
        PH_FILL:  op = (roll < 85) ? CMD_INSERT : (roll < 90) ? CMD_REMOVE : CMD_SEARCH;
        PH_DRAIN: op = (roll < 75) ? CMD_REMOVE : (roll < 80) ? CMD_INSERT :
                       (roll < 98) ? CMD_SEARCH : CMD_CLEAR;
        default:  op = (roll < 36) ? CMD_INSERT : (roll < 66) ? CMD_REMOVE :
                       (roll < 97) ? CMD_SEARCH : CMD_CLEAR;
      endcase
      send_request(op, pick_position(op), pick_value(op));
      phase_items++;
      case (ph)
        PH_FILL:  begin
          if (list_len == CAPACITY) extra++;
          done = (extra > 8);
        end
        PH_DRAIN: begin
          if (list_len == 0) extra++;
          done = (extra > 5);
        end
        default:  done = (phase_items >= 100);
      endcase
      if (done) begin
        turn++;
        case (turn % 4)
          0:       ph = PH_FILL;
          2:       ph = PH_DRAIN;
          default: ph = PH_MIX;
        endcase
        phase_items = 0;
        extra       = 0;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    steady = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/pal_pkg.sv
rtl/pal_dp.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_unit.sv
tb/pal_list_checker.sv
tb/positional_array_list_unit_tb.sv
